// ----- hw/rtl/base64_stream_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// base64_stream_decoder assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define B64D_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character constants and symbol lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PAD   = 8'h3D; // '='
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_ASCII_MAX = 8'd127;

	localparam logic [5:0] SYM_62 = 6'h3E;
	localparam logic [5:0] SYM_63 = 6'h3F;

	// configuration register indexes
	localparam logic REG_URL_SAFE = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	// final status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} b64d_sym_t;

	// results of one input character: up to three bytes, then an optional status
	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      n_data;
		logic            has_status;
		logic [1:0]      code;
	} b64d_bundle_t;

	function automatic b64d_sym_t sym_lookup(input logic [7:0] c);
		b64d_sym_t s;
		s.ok    = 1'b1;
		s.value = '0;
		if (c > CH_ASCII_MAX) begin
			s.ok = 1'b0;
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			s.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			s.value = SYM_62;
		end else if (c == CH_SLASH || c == CH_UNDER) begin
			s.value = SYM_63;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

endpackage

// ----- hw/rtl/base64_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, standard or URL-safe alphabet, with a byte budget.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one character per transaction in s_tdata[7:0];
//   s_tlast marks the final character of an encoded string. CR and LF are
//   skipped. The master stream returns decoded bytes (m_tuser = 0) and, after
//   the final character, one status transaction (m_tuser = 1, m_tlast = 1)
//   with code 0 ok, 1 invalid format, 2 not enough space. Discard the bytes
//   of a run whose status is nonzero.
//   A taken character waits in the input register, then its results load into
//   the result register. Throughput: one character per cycle while m_tready
//   is high, except after a completed quad (three bytes) or the end of a string
//   (up to four results), as the single result register drains one per cycle.
//   Receiver stall: the result register holds, the input register fills, and
//   s_tready drops until the pending results leave.
//   Reset clears the stream state and sets the standard alphabet and full
//   capacity. Write the configuration port only while the block is idle.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder import b64d_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] char_in
	input  logic                   s_tlast,   // last_char
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,   // [7:0] out_byte, [9:8] status_code
	output logic                   m_tuser,   // [0] is_status
	output logic                   m_tlast,   // end_of_run
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [COUNT_WIDTH-1:0] cfg_data
);

	logic                   url_q;
	logic [COUNT_WIDTH-1:0] cap_q;
	logic                   in_v_q;
	logic [7:0]             in_ch_q;
	logic                   in_last_q;
	logic                   can_load;
	logic                   advance;
	b64d_bundle_t           bundle;

	assign advance  = in_v_q && can_load;
	assign s_tready = !in_v_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_q <= 1'b0;
			cap_q <= {COUNT_WIDTH{1'b1}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_URL_SAFE: url_q <= cfg_data[0];
				REG_CAPACITY: cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_v_q <= 1'b1;
		end else if (advance) begin
			in_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_ch_q   <= s_tdata;
			in_last_q <= s_tlast;
		end
	end

	b64d_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.url_mode (url_q),
		.capacity (cap_q),
		.ch       (in_ch_q),
		.last     (in_last_q),
		.advance  (advance),
		.bundle   (bundle)
	);

	b64d_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_req (in_v_q),
		.bundle   (bundle),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// input only stalls behind pending results
	`B64D_ASSERT_IMP(a_stall_has_output, !s_tready, m_tvalid,
		"input stalled with no pending result")
	// a status transaction is the final result of its bundle
	`B64D_ASSERT_IMP(a_status_frees, m_tvalid && m_tready && m_tuser, can_load,
		"status transaction did not free the result register")
	// an accepted character is held for decode
	`B64D_ASSERT_NEXT(a_in_held, s_tvalid && s_tready, in_v_q,
		"accepted character lost from input register")

endmodule

// ----- hw/rtl/b64d_core.sv -----
// ----------------------------------------------------------------------------
// b64d_core
// Stream state (accumulator, phase, padding, error, byte count) and the
// single-pass decode of one held character into a result bundle.
// ----------------------------------------------------------------------------
module b64d_core import b64d_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   url_mode,
	input  logic [COUNT_WIDTH-1:0] capacity,
	input  logic [7:0]             ch,
	input  logic                   last,
	input  logic                   advance,
	output b64d_bundle_t           bundle
);

	localparam int CW = COUNT_WIDTH;
	localparam logic [CW:0] CNT_MAX = {(CW+1){1'b1}};

	logic [23:0] acc_q;
	logic [1:0]  phase_q;
	logic [1:0]  pad_q;
	logic        ferr_q;
	logic [CW:0] cnt_q;

	logic [23:0] acc_n;
	logic [1:0]  phase_n;
	logic [1:0]  pad_n;
	logic        ferr_n;
	logic [CW:0] cnt_n;

	b64d_sym_t       sym;
	logic            wrong_alpha;
	logic            quad;
	logic [2:0][7:0] cand;
	logic [1:0]      n_cand;
	logic [1:0]      n_emit;
	logic [CW+1:0]   cnt_ext;
	logic [CW+1:0]   cap_ext;
	logic [CW+1:0]   cnt_sum;
	logic            e0, e1, e2;

	assign sym = sym_lookup(ch);
	assign wrong_alpha = url_mode ? (ch == CH_PLUS || ch == CH_SLASH)
	                              : (ch == CH_MINUS || ch == CH_UNDER);

	always_comb begin
		acc_n   = acc_q;
		phase_n = phase_q;
		pad_n   = pad_q;
		ferr_n  = ferr_q;
		quad    = 1'b0;
		if (!ferr_q && ch != CH_CR && ch != CH_LF) begin
			if (ch == CH_PAD) begin
				if (pad_q >= 2'd2) ferr_n = 1'b1;
				else pad_n = pad_q + 2'd1;
			end else if (pad_q != 2'd0) begin
				ferr_n = 1'b1;
			end else if (wrong_alpha || !sym.ok) begin
				ferr_n = 1'b1;
			end else begin
				acc_n   = {acc_q[17:0], sym.value};
				phase_n = phase_q + 2'd1;
				quad    = (phase_q == 2'd3);
			end
		end
	end

	// candidate bytes: a completed quad, or the tail on the last character
	always_comb begin
		cand   = '0;
		n_cand = 2'd0;
		if (quad) begin
			cand   = {acc_n[7:0], acc_n[15:8], acc_n[23:16]};
			n_cand = 2'd3;
		end else if (last && !ferr_n) begin
			if (phase_n == 2'd3) begin
				cand   = {8'h00, acc_n[9:2], acc_n[17:10]};
				n_cand = 2'd2;
			end else if (phase_n == 2'd2) begin
				cand   = {8'h00, 8'h00, acc_n[11:4]};
				n_cand = 2'd1;
			end
		end
	end

	// bytes pass while the running count stays below capacity
	assign cnt_ext = {1'b0, cnt_q};
	assign cap_ext = {2'b00, capacity};
	assign e0 = cnt_ext < cap_ext;
	assign e1 = (cnt_ext + (CW+2)'(1)) < cap_ext;
	assign e2 = (cnt_ext + (CW+2)'(2)) < cap_ext;
	assign cnt_sum = cnt_ext + (CW+2)'(n_cand);
	assign cnt_n = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[CW:0];

	always_comb begin
		n_emit = 2'd0;
		if (n_cand > 2'd0 && e0) n_emit = 2'd1;
		if (n_cand > 2'd1 && e1) n_emit = 2'd2;
		if (n_cand > 2'd2 && e2) n_emit = 2'd3;
	end

	always_comb begin
		bundle.data       = cand;
		bundle.n_data     = n_emit;
		bundle.has_status = last;
		if (ferr_n || phase_n == 2'd1) bundle.code = ST_INVALID;
		else if ({1'b0, cnt_n} > cap_ext) bundle.code = ST_NOSPACE;
		else bundle.code = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			phase_q <= '0;
			pad_q   <= '0;
			ferr_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (advance) begin
			if (last) begin
				acc_q   <= '0;
				phase_q <= '0;
				pad_q   <= '0;
				ferr_q  <= 1'b0;
				cnt_q   <= '0;
			end else begin
				acc_q   <= acc_n;
				phase_q <= phase_n;
				pad_q   <= pad_n;
				ferr_q  <= ferr_n;
				cnt_q   <= cnt_n;
			end
		end
	end

endmodule

// ----- hw/rtl/b64d_serial.sv -----
// ----------------------------------------------------------------------------
// b64d_serial
// Result register: holds one bundle; drains one transaction per ready cycle.
// ----------------------------------------------------------------------------
module b64d_serial import b64d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load_req,
	input  b64d_bundle_t bundle,
	output logic         can_load,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata,  // [7:0] out_byte, [9:8] status_code, rest zero
	output logic         m_tuser,  // [0] is_status
	output logic         m_tlast   // end_of_run
);

	b64d_bundle_t bnd_q;
	logic [2:0]   left_q;
	logic [1:0]   pos_q;
	logic         is_stat;
	logic         load;
	logic [7:0]   byte_out;
	logic [1:0]   code_out;

	assign m_tvalid = (left_q != 3'd0);
	assign can_load = (left_q == 3'd0) || (left_q == 3'd1 && m_tready);
	assign load     = load_req && can_load;

	assign is_stat  = (pos_q >= bnd_q.n_data);
	assign byte_out = is_stat ? 8'h00 : bnd_q.data[pos_q];
	assign code_out = is_stat ? bnd_q.code : ST_OK;

	assign m_tdata = {6'b000000, code_out, byte_out};
	assign m_tuser = is_stat;
	assign m_tlast = is_stat;

	always_ff @(posedge clk) begin
		if (load) bnd_q <= bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			pos_q  <= '0;
		end else if (load) begin
			left_q <= {1'b0, bundle.n_data} + {2'b00, bundle.has_status};
			pos_q  <= '0;
		end else if (m_tvalid && m_tready) begin
			// advance to the next result of the bundle
			left_q <= left_q - 3'd1;
			pos_q  <= pos_q + 2'd1;
		end
	end

endmodule
